// File: rtl/mpm_pkg.sv
package mpm_pkg;

  localparam int unsigned PerrW   = 18;      // 4 * 255^2 < 2^18
  localparam int unsigned LogW    = 22;      // 6-bit exponent, 16-bit fraction
  localparam int unsigned PeakSq  = 65025;
  localparam int unsigned DbQ16   = 197283;  // 10*log10(2) in Q16

  typedef enum logic [1:0] {
    ST_MEASURED  = 2'd0,
    ST_ZERO_ERR  = 2'd1,
    ST_EMPTY     = 2'd2
  } mpm_status_e;

  typedef struct packed {
    logic [PerrW-1:0] perr;
    logic             counted;
    logic             eof;
  } mpm_item_t;

  typedef enum logic [3:0] {
    BK_ACC, BK_CHK, BK_MUL, BK_LNGO, BK_LNWT, BK_LDGO, BK_LDWT, BK_SCL, BK_FIN
  } mpm_back_e;

  typedef enum logic [1:0] {
    LG_IDLE, LG_NORM, LG_SQR, LG_DONE
  } mpm_log_e;

  function automatic logic [2:0] mpm_ch(input logic [2:0] cfg, input logic [2:0] max_ch);
    logic [2:0] c;
    c = cfg;
    if (c == 3'd0) c = 3'd1;
    if (c > max_ch) c = max_ch;
    return c;
  endfunction

endpackage

// File: rtl/mpm_front.sv
module mpm_front #(
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic [2:0]         ch_i,
  input  logic [7:0]         frame_ch0_i,
  input  logic [7:0]         frame_ch1_i,
  input  logic [7:0]         frame_ch2_i,
  input  logic [7:0]         frame_ch3_i,
  input  logic [7:0]         ref_ch0_i,
  input  logic [7:0]         ref_ch1_i,
  input  logic [7:0]         ref_ch2_i,
  input  logic [7:0]         ref_ch3_i,
  input  logic               end_of_frame_i,
  output mpm_pkg::mpm_item_t item_o
);
  import mpm_pkg::*;

  logic [7:0]       f [4];
  logic [7:0]       r [4];
  logic [2:0]       ch;
  logic [PerrW-1:0] perr;
  logic             black_f, black_r;
  logic [7:0]       d;

  assign f[0] = frame_ch0_i;
  assign f[1] = frame_ch1_i;
  assign f[2] = frame_ch2_i;
  assign f[3] = frame_ch3_i;
  assign r[0] = ref_ch0_i;
  assign r[1] = ref_ch1_i;
  assign r[2] = ref_ch2_i;
  assign r[3] = ref_ch3_i;
  assign ch   = mpm_ch(ch_i, 3'(MAX_CHANNELS));

  always_comb begin
    perr    = '0;
    black_f = 1'b1;
    black_r = 1'b1;
    d       = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < ch) begin
        d = (f[k] > r[k]) ? (f[k] - r[k]) : (r[k] - f[k]);
        perr = perr + PerrW'(d) * PerrW'(d);
        if (f[k] != 8'd0) black_f = 1'b0;
        if (r[k] != 8'd0) black_r = 1'b0;
      end
    end
  end

  assign item_o.perr    = perr;
  assign item_o.counted = !(black_f || black_r);
  assign item_o.eof     = end_of_frame_i;

endmodule

// File: rtl/mpm_queue.sv
module mpm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mpm_pkg::mpm_item_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output mpm_pkg::mpm_item_t data_o
);
  import mpm_pkg::*;

  mpm_item_t  mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// File: rtl/mpm_log2.sv
module mpm_log2 #(
  parameter int unsigned XW = 41
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [XW-1:0]             x_i,
  output logic                      done_o,
  output logic [mpm_pkg::LogW-1:0]  res_o
);
  import mpm_pkg::*;

  mpm_log_e    state_q, state_d;
  logic [XW-1:0] x_q;
  logic [5:0]  e_q;
  logic [30:0] m_q;
  logic [15:0] f_q;
  logic [3:0]  it_q;
  logic [61:0] sq;
  logic [31:0] t;

  assign sq = m_q * m_q;
  assign t  = sq[61:30];

  always_comb begin
    state_d = state_q;
    case (state_q)
      LG_IDLE: if (start_i) state_d = LG_NORM;
      LG_NORM: if (x_q[XW-1]) state_d = LG_SQR;
      LG_SQR:  if (it_q == 4'd15) state_d = LG_DONE;
      LG_DONE: state_d = LG_IDLE;
      default: state_d = LG_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == LG_DONE);
    res_o  = {e_q, f_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= LG_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      LG_IDLE: begin
        x_q  <= x_i;
        e_q  <= 6'(XW - 1);
        it_q <= '0;
      end
      LG_NORM: begin
        if (x_q[XW-1]) begin
          m_q <= x_q[XW-1 -: 31];
        end else begin
          x_q <= x_q << 1;
          e_q <= e_q - 6'd1;
        end
      end
      LG_SQR: begin
        f_q  <= {f_q[14:0], t[31]};
        m_q  <= t[31] ? t[31:1] : t[30:0];
        it_q <= it_q + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/mpm_back.sv
module mpm_back #(
  parameter int unsigned MAX_CHANNELS     = 4,
  parameter int unsigned PIXEL_COUNT_BITS = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         ch_i,
  input  logic               empty_i,
  input  mpm_pkg::mpm_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        psnr_q8_o,
  output logic [1:0]         frame_status_o,
  output logic [22:0]        counted_pixels_o
);
  import mpm_pkg::*;

  localparam int unsigned CW = PIXEL_COUNT_BITS + 1;
  localparam int unsigned NW = CW + PerrW;
  localparam int unsigned XW = (NW > 40) ? NW : 40;

  mpm_back_e        state_q, state_d;
  logic [39:0]      err_q;
  logic [CW-1:0]    cnt_q;
  logic [XW-1:0]    num_q;
  logic [LogW-1:0]  lnum_q;
  logic signed [LogW:0] d_q;
  logic [39:0]      prod_q;
  logic             out_valid_q;
  logic [15:0]      psnr_q;
  mpm_status_e      status_q;
  logic [22:0]      cpix_q;

  logic             log_start, log_done;
  logic [XW-1:0]    log_x;
  logic [LogW-1:0]  log_res;
  logic [40:0]      err_sum;
  logic [PerrW-1:0] pk;
  logic [26:0]      cnt_ext;
  logic [16:0]      v;

  assign err_sum = {1'b0, err_q} + 41'(item_i.perr);
  assign pk      = PerrW'(PeakSq) * PerrW'(mpm_ch(ch_i, 3'(MAX_CHANNELS)));
  assign cnt_ext = 27'(cnt_q);
  assign v       = 17'((prod_q + 40'(1 << 23)) >> 24);

  mpm_log2 #(.XW(XW)) u_log (
    .clk_i, .rst_ni,
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .res_o   (log_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_ACC:  if (pop_o && item_i.eof) state_d = BK_CHK;
      BK_CHK:  state_d = (cnt_q == '0 || err_q == '0) ? BK_ACC : BK_MUL;
      BK_MUL:  state_d = BK_LNGO;
      BK_LNGO: state_d = BK_LNWT;
      BK_LNWT: if (log_done) state_d = BK_LDGO;
      BK_LDGO: state_d = BK_LDWT;
      BK_LDWT: if (log_done) state_d = BK_SCL;
      BK_SCL:  state_d = BK_FIN;
      BK_FIN:  state_d = BK_ACC;
      default: state_d = BK_ACC;
    endcase
  end

  always_comb begin
    pop_o     = (state_q == BK_ACC) && !empty_i && !(item_i.eof && out_valid_q);
    log_start = (state_q == BK_LNGO) || (state_q == BK_LDGO);
    log_x     = (state_q == BK_LNGO) ? num_q : XW'(err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_ACC;
      err_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        BK_ACC: begin
          // count stops at 2^PIXEL_COUNT_BITS, i.e. once the top bit is set
          if (pop_o && item_i.counted && !cnt_q[CW-1]) begin
            err_q <= err_sum[40] ? 40'hFF_FFFF_FFFF : err_sum[39:0];
            cnt_q <= cnt_q + 1'b1;
          end
        end
        BK_CHK: begin
          if (cnt_q == '0 || err_q == '0) begin
            out_valid_q <= 1'b1;
            err_q       <= '0;
            cnt_q       <= '0;
          end
        end
        BK_FIN: begin
          out_valid_q <= 1'b1;
          err_q       <= '0;
          cnt_q       <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_CHK: begin
        psnr_q   <= '0;
        cpix_q   <= cnt_ext[22:0];
        status_q <= (cnt_q == '0) ? ST_EMPTY : (err_q == '0) ? ST_ZERO_ERR : ST_MEASURED;
      end
      BK_MUL:  num_q <= XW'(cnt_q) * XW'(pk);
      BK_LNWT: if (log_done) lnum_q <= log_res;
      BK_LDWT: if (log_done) d_q <= $signed({1'b0, lnum_q}) - $signed({1'b0, log_res});
      BK_SCL:  prod_q <= (d_q > 0) ? 40'(d_q[LogW-1:0]) * 40'(DbQ16) : '0;
      BK_FIN:  psnr_q <= v[16] ? 16'hFFFF : v[15:0];
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign psnr_q8_o        = psnr_q;
  assign frame_status_o   = status_q;
  assign counted_pixels_o = cpix_q;

endmodule

// File: rtl/masked_psnr_meter.sv
// channel   | valid       | stall       | payload
// pixel in  | in_valid_i  | in_stall_o  | frame_ch0..3_i, ref_ch0..3_i, end_of_frame_i
// result    | out_valid_o | out_stall_i | psnr_q8_o, frame_status_o, counted_pixels_o
// config    | cfg_we_i    | -           | cfg_data_i (channels in use)
// Pixel items are classified and squared in the front and accumulated by the
// back at one per cycle while it is accumulating, through a two-entry queue.
// End of frame runs the shared bit-serial log2 unit twice (normalize shift,
// then 16 squaring steps); pixels queue up behind it meanwhile.
// Reset clears the sums and sets channels in use to 3.
// A waiting result does not block pixel items, only the next end of frame.
module masked_psnr_meter #(
  parameter int unsigned MAX_CHANNELS     = 4,
  parameter int unsigned PIXEL_COUNT_BITS = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_ch0_i,
  input  logic [7:0]  frame_ch1_i,
  input  logic [7:0]  frame_ch2_i,
  input  logic [7:0]  frame_ch3_i,
  input  logic [7:0]  ref_ch0_i,
  input  logic [7:0]  ref_ch1_i,
  input  logic [7:0]  ref_ch2_i,
  input  logic [7:0]  ref_ch3_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] psnr_q8_o,
  output logic [1:0]  frame_status_o,
  output logic [22:0] counted_pixels_o
);
  import mpm_pkg::*;

  logic [2:0] ch_q;
  mpm_item_t  fr_item, q_item;
  logic       q_full, q_empty, pop, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       ch_q <= 3'd3;
    else if (cfg_we_i) ch_q <= cfg_data_i;
  end

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  mpm_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .ch_i (ch_q),
    .frame_ch0_i, .frame_ch1_i, .frame_ch2_i, .frame_ch3_i,
    .ref_ch0_i, .ref_ch1_i, .ref_ch2_i, .ref_ch3_i,
    .end_of_frame_i,
    .item_o (fr_item)
  );

  mpm_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (q_item)
  );

  mpm_back #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_back (
    .clk_i, .rst_ni,
    .ch_i    (ch_q),
    .empty_i (q_empty),
    .item_i  (q_item),
    .pop_o   (pop),
    .out_valid_o, .out_stall_i,
    .psnr_q8_o, .frame_status_o, .counted_pixels_o
  );

endmodule

// File: rtl/mpm_checker.sv
module mpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] psnr_q8_o,
  input logic [1:0]  frame_status_o,
  input logic [22:0] counted_pixels_o
);
  import mpm_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(psnr_q8_o))
    else $error("result dropped while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o == ST_EMPTY |-> psnr_q8_o == 16'd0 && counted_pixels_o == '0)
    else $error("empty frame with nonzero fields");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o == ST_ZERO_ERR |-> psnr_q8_o == 16'd0)
    else $error("zero-error frame with nonzero psnr");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_status_o != 2'd3)
    else $error("bad status code");

endmodule

bind masked_psnr_meter mpm_checker u_mpm_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i,
  .psnr_q8_o, .frame_status_o, .counted_pixels_o
);
